[src/dprc_pkg.sv]
// Shared types and constants for the data packet receive checker.
// No dependencies; the files that use it refer to this package by scoped names.
package dprc_pkg;

  localparam int POS_W = 12;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Byte positions that open each header field; the payload follows the header.
  localparam logic [POS_W-1:0] CLOSE_POS    = 12'd0;
  localparam logic [POS_W-1:0] SEQ_POS      = 12'd1;
  localparam logic [POS_W-1:0] TOTAL_POS    = 12'd5;
  localparam logic [POS_W-1:0] CSUM_POS     = 12'd9;
  localparam logic [POS_W-1:0] LEN_POS      = 12'd13;
  localparam logic [POS_W-1:0] HEADER_BYTES = 12'd17;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [30:0] bytes_received;
  } in_t;

  typedef struct packed {
    logic               verdict;
    logic [7:0]         close_flag;
    logic signed [31:0] seq_number;
    logic signed [31:0] total_size;
    logic signed [31:0] payload_length;
  } out_t;

  // One finished frame as the parser hands it to the checker stage.
  typedef struct packed {
    logic [7:0]         close_flag;
    logic signed [31:0] seq;
    logic signed [31:0] total;
    logic [31:0]        csum;
    logic signed [31:0] length;
    logic [31:0]        run_sum;
    logic [30:0]        rcvd;
  } frame_rec_t;

endpackage

[src/data_packet_receive_checker_core.sv]
// Records pass the frame queue and checker register into the result queue.
// Throughput: one byte per cycle; one checker verdict per cycle unless res_full.
// The parser stalls (in_full) only when the frame queue to the checker is full.
// Reset (rst_n low, synchronous) empties both queues, clears per-frame state
// and sets expected_bytes to zero.
module data_packet_receive_checker_core #(
  parameter int MAX_PAYLOAD       = 1024,
  parameter int FRAME_QUEUE_DEPTH = 2,
  parameter int RESULT_QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  // Input request channel: one frame byte per request.
  input  logic           in_push,
  input  dprc_pkg::in_t  in_data,
  output logic           in_full,
  // Result channel: one verdict plus header fields per frame.
  output logic           out_empty,
  input  logic           out_pop,
  output dprc_pkg::out_t out_data,
  // Configuration: expected transfer size.
  input  logic           cfg_wr_en,
  input  logic [30:0]    cfg_wr_data
);

  logic [30:0]          expected_r;

  logic                 rec_push, rec_full, rec_pop, rec_empty;
  dprc_pkg::frame_rec_t rec_in, rec_out;

  logic                 res_push, res_full;
  dprc_pkg::out_t       res_data;

  // Expected size: the user writes it only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
    end else if (cfg_wr_en) begin
      expected_r <= cfg_wr_data;
    end
  end

  // Front: parse header bytes, accumulate the payload sum, emit a record per frame.
  dprc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec_data (rec_in)
  );

  // Decouple the parser from the checker so either side may stall alone.
  dprc_fifo #(
    .item_t (dprc_pkg::frame_rec_t),
    .DEPTH  (FRAME_QUEUE_DEPTH)
  ) u_frame_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .din   (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .dout  (rec_out),
    .empty (rec_empty)
  );

  // Back: apply the packet rules and produce the verdict.
  dprc_judge #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_judge (
    .clk            (clk),
    .rst_n          (rst_n),
    .expected_bytes (expected_r),
    .rec_empty      (rec_empty),
    .rec_data       (rec_out),
    .rec_pop        (rec_pop),
    .res_full       (res_full),
    .res_push       (res_push),
    .res_data       (res_data)
  );

  // Results wait here until the consumer pops them.
  dprc_fifo #(
    .item_t (dprc_pkg::out_t),
    .DEPTH  (RESULT_QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

endmodule

[src/dprc_fifo.sv]
// Small first-in first-out queue of registers with empty/full flags.
// Generic over the item type; used between parser and checker and at the output.
module dprc_fifo #(
  parameter type item_t = logic [7:0],
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/dprc_front.sv]
// Frame parser: builds header words and payload sum one byte per cycle while
// rec_full is low. Uses dprc_pkg; pushes a frame_rec_t on each final byte.
module dprc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  dprc_pkg::in_t      in_data,
  output logic               in_full,
  input  logic               rec_full,
  output logic               rec_push,
  output dprc_pkg::frame_rec_t rec_data
);

  logic [dprc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  close_r, close_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] csum_r, csum_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic        accept;
  logic [1:0]  lane;
  logic [7:0]  b;
  logic [dprc_pkg::POS_W-1:0] pay_idx;
  logic        in_payload;

  function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] ln,
                                           input logic [7:0] v);
    logic [31:0] r;
    r = w;
    r[ln*8 +: 8] = v;
    return r;
  endfunction

  assign accept  = in_push && !rec_full;
  assign in_full = rec_full;
  assign b       = in_data.frame_byte;
  // Every header word starts one past a multiple of four.
  assign lane    = pos_r[1:0] - 2'd1;
  assign pay_idx = pos_r - dprc_pkg::HEADER_BYTES;
  assign in_payload = (pos_r >= dprc_pkg::HEADER_BYTES) && !len_r[31] &&
                      ({20'd0, pay_idx} < len_r);

  always_comb begin
    close_nxt = close_r;
    seq_nxt   = seq_r;
    total_nxt = total_r;
    csum_nxt  = csum_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    if (pos_r == dprc_pkg::CLOSE_POS) begin
      close_nxt = b;
    end else if (pos_r < dprc_pkg::TOTAL_POS) begin
      seq_nxt = put_lane(seq_r, lane, b);
    end else if (pos_r < dprc_pkg::CSUM_POS) begin
      total_nxt = put_lane(total_r, lane, b);
    end else if (pos_r < dprc_pkg::LEN_POS) begin
      csum_nxt = put_lane(csum_r, lane, b);
    end else if (pos_r < dprc_pkg::HEADER_BYTES) begin
      len_nxt = put_lane(len_r, lane, b);
    end else if (in_payload) begin
      sum_nxt = sum_r + {{24{b[7]}}, b};
    end
    pos_nxt = (pos_r == dprc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;
  end

  assign rec_push            = accept && in_data.frame_end;
  assign rec_data.close_flag = close_nxt;
  assign rec_data.seq        = signed'(seq_nxt);
  assign rec_data.total      = signed'(total_nxt);
  assign rec_data.csum       = csum_nxt;
  assign rec_data.length     = signed'(len_nxt);
  assign rec_data.run_sum    = sum_nxt;
  assign rec_data.rcvd       = in_data.bytes_received;

  always_ff @(posedge clk) begin
    if (!rst_n || rec_push) begin
      // Clear all per-frame state once the frame has been handed on.
      pos_r   <= '0;
      close_r <= '0;
      seq_r   <= '0;
      total_r <= '0;
      csum_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      close_r <= close_nxt;
      seq_r   <= seq_nxt;
      total_r <= total_nxt;
      csum_r  <= csum_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

[src/dprc_judge.sv]
// Frame checker: applies the packet rules to a frame record per cycle unless res_full.
// Uses dprc_pkg; a multiply stage feeds the rule compare that writes the result queue.
module dprc_judge #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [30:0]          expected_bytes,
  input  logic                 rec_empty,
  input  dprc_pkg::frame_rec_t rec_data,
  output logic                 rec_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output dprc_pkg::out_t       res_data
);

  localparam int MW = $clog2(MAX_PAYLOAD + 1);
  localparam int PW = 32 + MW + 1;
  localparam logic signed [MW:0]   MAXP_S = (MW + 1)'(MAX_PAYLOAD);
  localparam logic signed [31:0]   MAXP_W = 32'(MAX_PAYLOAD);
  localparam logic signed [PW-1:0] MAXP_P = PW'(MAXP_S);

  dprc_pkg::frame_rec_t s1_rec_r;
  logic                 s1_v_r;
  logic signed [PW-1:0] s1_prod_r;
  logic                 advance;

  logic signed [PW-1:0] exp_p, prod_next;
  logic [31:0]          remain;
  logic                 seq_is_last, seq_before_last, bad;

  assign advance  = !s1_v_r || !res_full;
  assign rec_pop  = !rec_empty && advance;
  assign res_push = s1_v_r && !res_full;

  // seq * MAX_PAYLOAD, registered before the rule compare.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rec_r  <= rec_data;
      s1_prod_r <= PW'(rec_data.seq) * MAXP_P;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= !rec_empty;
    end
  end

  // With P = ceil(expected / MAX_PAYLOAD): seq == P-1 holds exactly when
  // seq*M < expected <= (seq+1)*M, and seq < P-1 when (seq+1)*M < expected.
  always_comb begin
    exp_p           = PW'(signed'({1'b0, expected_bytes}));
    prod_next       = s1_prod_r + MAXP_P;
    seq_is_last     = (s1_prod_r < exp_p) && (prod_next >= exp_p);
    seq_before_last = (prod_next < exp_p);
    remain          = {1'b0, expected_bytes} - {1'b0, s1_rec_r.rcvd};
    bad = 1'b0;
    if (s1_rec_r.seq == 32'sd0 && s1_rec_r.length == 32'sd0) bad = 1'b1;
    if (s1_rec_r.length <= 32'sd0) bad = 1'b1;
    if (seq_is_last && (remain != s1_rec_r.length)) bad = 1'b1;
    if (seq_before_last && (s1_rec_r.length < MAXP_W)) bad = 1'b1;
    if (s1_rec_r.total == 32'sd0 && s1_rec_r.seq > 32'sd0) bad = 1'b1;
    if (s1_rec_r.length > MAXP_W) bad = 1'b1;
    if (s1_rec_r.run_sum != s1_rec_r.csum) bad = 1'b1;
  end

  assign res_data.verdict        = bad;
  assign res_data.close_flag     = s1_rec_r.close_flag;
  assign res_data.seq_number     = s1_rec_r.seq;
  assign res_data.total_size     = s1_rec_r.total;
  assign res_data.payload_length = s1_rec_r.length;

endmodule

[src/dprc_checker.sv]
// Port-level checks for data_packet_receive_checker_core, attached by bind.
// Uses dprc_pkg for the channel types.
module dprc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_push,
  input dprc_pkg::in_t  in_data,
  input logic           in_full,
  input logic           out_empty,
  input logic           out_pop,
  input dprc_pkg::out_t out_data
);

  logic [3:0] pending_r;
  logic       frame_in, res_out;

  assign frame_in = in_push && !in_full && in_data.frame_end;
  assign res_out  = out_pop && !out_empty;

  // Count frames whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      case ({frame_in, res_out})
        2'b10:   pending_r <= pending_r + 1'b1;
        2'b01:   pending_r <= pending_r - 1'b1;
        default: pending_r <= pending_r;
      endcase
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 4'd0 |-> out_empty)
    else $error("result without a finished frame");

  // For an idle block the record passes the frame queue and the checker register
  // before the result lands in the output queue and shows as not empty.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    frame_in && pending_r == 4'd0 |-> ##3 !out_empty)
    else $error("result late for an idle block");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

endmodule

bind data_packet_receive_checker_core dprc_checker u_dprc_checker (.*);

[test/data_packet_receive_checker_core_tb.sv]
// Self-checking bench for data_packet_receive_checker_core: frames of bytes go in,
// and each verdict is compared with a frame checker predicted inside the bench.
// Depends on dprc_pkg (src/dprc_pkg.sv) and the core RTL only.
module data_packet_receive_checker_core_tb;

  localparam int MAX_PAYLOAD = 1024;
  localparam int ITEM_TARGET = 1150;
  localparam int TAIL_ITEMS = 170;
  localparam int PHASE_ITEMS = 200;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_push = 1'b0;
  dprc_pkg::in_t  in_data = '0;
  logic           in_full;
  logic           out_empty;
  logic           out_pop = 1'b0;
  dprc_pkg::out_t out_data;
  logic           cfg_wr_en = 1'b0;
  logic [30:0]    cfg_wr_data = '0;

  data_packet_receive_checker_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and verdicts waiting to come out.
  dprc_pkg::in_t  byte_q[$];
  dprc_pkg::out_t verdict_q[$];

  int             err_n = 0;
  int             item_n = 0;
  int             frame_n = 0;
  int             acc_n = 0;
  int             tx_gap = 0;
  int             rx_gap = 0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  bit             no_idle = 1'b0;
  logic           rx_hold = 1'b0;
  dprc_pkg::out_t head_v;

  // Frame checker state as the bench predicts it.
  logic [30:0]                p_exp = '0;
  logic [dprc_pkg::POS_W-1:0] p_pos = '0;
  logic [7:0]                 p_close = '0;
  logic signed [31:0]         p_seq = '0;
  logic signed [31:0]         p_tot = '0;
  logic [31:0]                p_csum = '0;
  logic signed [31:0]         p_len = '0;
  logic [31:0]                p_sum = '0;

  // Stimulus copy of the transfer size, used to shape well-formed frames.
  logic [30:0] exp_now = '0;

  task automatic flag_error(input string what);
    if (err_n < 50) $display("ERROR at %0t: %s", $time, what);
    err_n++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Apply the corruption rules to the frame just closed.
  function automatic bit frame_is_corrupt(input logic [30:0] rcvd);
    longint sq, tt, ln, ex, pk, rv;
    sq = p_seq;
    tt = p_tot;
    ln = p_len;
    ex = p_exp;
    rv = rcvd;
    pk = ex / MAX_PAYLOAD + (((ex % MAX_PAYLOAD) > 0) ? 1 : 0);
    return (sq == 0 && ln == 0) || (ln <= 0) || (sq == pk - 1 && (ex - rv) != ln) ||
           (sq < pk - 1 && ln < MAX_PAYLOAD) || (tt == 0 && sq > 0) ||
           (ln > MAX_PAYLOAD) || (p_sum != p_csum);
  endfunction

  // Advance the predicted parser by one accepted byte; queue a verdict at frame end.
  task automatic take_byte(input dprc_pkg::in_t it);
    dprc_pkg::out_t v;
    logic [7:0]     b;
    b = it.frame_byte;
    if (p_pos == dprc_pkg::CLOSE_POS) begin
      p_close = b;
    end else if (p_pos < dprc_pkg::TOTAL_POS) begin
      p_seq[(p_pos - dprc_pkg::SEQ_POS) * 8 +: 8] = b;
    end else if (p_pos < dprc_pkg::CSUM_POS) begin
      p_tot[(p_pos - dprc_pkg::TOTAL_POS) * 8 +: 8] = b;
    end else if (p_pos < dprc_pkg::LEN_POS) begin
      p_csum[(p_pos - dprc_pkg::CSUM_POS) * 8 +: 8] = b;
    end else if (p_pos < dprc_pkg::HEADER_BYTES) begin
      p_len[(p_pos - dprc_pkg::LEN_POS) * 8 +: 8] = b;
    end else if ((int'(p_pos) - int'(dprc_pkg::HEADER_BYTES)) < p_len) begin
      // Payload bytes count as signed values, only up to the length field.
      p_sum = p_sum + {{24{b[7]}}, b};
    end
    if (p_pos != dprc_pkg::POS_MAX) p_pos = p_pos + 1'b1;
    if (it.frame_end) begin
      v.verdict        = frame_is_corrupt(it.bytes_received);
      v.close_flag     = p_close;
      v.seq_number     = p_seq;
      v.total_size     = p_tot;
      v.payload_length = p_len;
      verdict_q = {verdict_q, v};
      p_pos   = '0;
      p_close = '0;
      p_seq   = '0;
      p_tot   = '0;
      p_csum  = '0;
      p_len   = '0;
      p_sum   = '0;
    end
  endtask

  // Build one frame: header fields, random payload, optional header cut.
  task automatic queue_frame(input logic [7:0] cls, input logic [31:0] seq,
                             input logic [31:0] tot, input logic [31:0] len,
                             input int n_pay, input int cut, input bit sum_ok,
                             input logic [30:0] rcvd);
    logic [7:0]    hdr [17];
    logic [7:0]    pay [$];
    logic [31:0]   sum;
    logic [31:0]   csum;
    int            n;
    dprc_pkg::in_t it;
    sum = '0;
    for (int i = 0; i < n_pay; i++) begin
      pay = {pay, 8'($urandom)};
      if (i < $signed(len)) sum = sum + {{24{pay[i][7]}}, pay[i]};
    end
    csum = sum_ok ? sum : $urandom;
    hdr[0] = cls;
    for (int k = 0; k < 4; k++) begin
      hdr[1 + k]  = seq[8 * k +: 8];
      hdr[5 + k]  = tot[8 * k +: 8];
      hdr[9 + k]  = csum[8 * k +: 8];
      hdr[13 + k] = len[8 * k +: 8];
    end
    n = (cut < 17) ? cut : 17 + n_pay;
    for (int i = 0; i < n; i++) begin
      it.frame_byte     = (i < 17) ? hdr[i] : pay[i - 17];
      it.frame_end      = (i == n - 1);
      it.bytes_received = rcvd;
      byte_q = {byte_q, it};
      item_n++;
    end
    frame_n++;
  endtask

  // Well-formed frame for the current transfer size: either the closing
  // packet with an exact length, or a middle packet with a full length field.
  task automatic queue_good_frame();
    longint      ex, pk;
    int          len;
    logic [31:0] seq, tot;
    ex  = exp_now;
    pk  = (ex + MAX_PAYLOAD - 1) / MAX_PAYLOAD;
    tot = $urandom;
    if (tot == 0) tot = 1;
    if (ex >= 1 && $urandom_range(0, 1)) begin
      len = $urandom_range(1, 24);
      if (len > ex) len = int'(ex);
      seq = 32'(pk - 1);
      // Sometimes trail a few bytes past the length; they must not count.
      queue_frame($urandom, seq, tot, len,
                  len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0),
                  17, 1'b1, 31'(ex - len));
    end else begin
      if (pk >= 2) seq = $urandom_range(0, 32'(pk - 2));
      else seq = 32'(pk - 2 - $urandom_range(0, 1000));
      // Send fewer payload bytes than the length says; the rest add nothing.
      queue_frame($urandom, seq, tot, MAX_PAYLOAD, $urandom_range(0, 24), 17, 1'b1,
                  31'($urandom));
    end
  endtask

  // Broken or odd frame: extreme fields, bad sums, cut headers.
  task automatic queue_noise_frame();
    longint      pk;
    logic [31:0] seq, tot, len;
    logic [30:0] rcvd;
    int          cut;
    pk = (longint'(exp_now) + MAX_PAYLOAD - 1) / MAX_PAYLOAD;
    case ($urandom_range(0, 7))
      0: len = 32'd0;
      1: len = 32'hFFFF_FFFF;
      2: len = 32'h8000_0000;
      3: len = MAX_PAYLOAD;
      4: len = MAX_PAYLOAD + 1;
      5: len = $urandom_range(1, 30);
      6: len = $urandom;
      default: len = 32'h7FFF_FFFF;
    endcase
    case ($urandom_range(0, 5))
      0: seq = 32'd0;
      1: seq = 32'(pk - 1);
      2: seq = $urandom;
      3: seq = $urandom_range(0, 5);
      4: seq = 32'h7FFF_FFFF;
      default: seq = 32'h8000_0000;
    endcase
    tot  = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom;
    rcvd = $urandom_range(0, 1) ? 31'($urandom) : 31'(exp_now - len);
    cut  = $urandom_range(0, 4) == 0 ? $urandom_range(1, 16) : 17;
    queue_frame($urandom, seq, tot, len, $urandom_range(0, 24), cut,
                $urandom_range(0, 1), rcvd);
  endtask

  // Wait until every request is taken and every verdict is out, then let
  // the checker pipeline settle before touching the register.
  task automatic drain();
    while (byte_q.size() != 0 || in_push) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_expected(input logic [30:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_exp   = v;
    exp_now = v;
  endtask

  // Driver: hold a request until it is taken, otherwise advance to the next
  // pending byte, dropping into idle bursts at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        take_byte(in_data);
        void'(byte_q.pop_front());
        acc_n++;
      end
      if (in_push && in_full) begin
        // hold the current request
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_push <= 1'b0;
      end else if (byte_q.size() == 0) begin
        in_push <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
        tx_gap = $urandom_range(0, 10);
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_data <= byte_q[0];
      end
    end
  end

  // Monitor: check each taken verdict against the oldest prediction, then
  // pick the next pop, honoring the long hold-off and random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          flag_error("verdict with no frame outstanding");
        end else begin
          head_v = verdict_q.pop_front();
          check_field("verdict", 32'(out_data.verdict), 32'(head_v.verdict));
          check_field("close_flag", 32'(out_data.close_flag), 32'(head_v.close_flag));
          check_field("seq_number", out_data.seq_number, head_v.seq_number);
          check_field("total_size", out_data.total_size, head_v.total_size);
          check_field("payload_length", out_data.payload_length, head_v.payload_length);
        end
      end
      if (rx_hold) begin
        out_pop <= 1'b0;
      end else if (no_idle) begin
        out_pop <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_pop <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 10);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Back-pressure: stop popping for a long stretch mid-run, while plenty of
  // bytes are still pending, so the frame and result queues fill and the
  // core stalls its input.
  initial begin
    while (acc_n < 230 || byte_q.size() < 180) @(posedge clk);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          ph;
    int          start;
    logic [30:0] v;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset transfer size of zero: close byte only,
    // header cut inside the total word, and a header-only middle packet.
    queue_frame(8'hFF, 32'h0, 32'h0, 32'h0, 0, 1, 1'b1, 31'h0);
    queue_frame(8'h00, 32'h8000_0001, 32'h0, 32'h0, 0, 6, 1'b1, 31'h7FFF_FFFF);
    queue_frame(8'hA5, 32'hFFFF_FFFE, 32'h0, MAX_PAYLOAD, 0, 17, 1'b1, 31'h0);
    drain();

    ph = 0;
    while (item_n < ITEM_TARGET - TAIL_ITEMS) begin
      case (ph)
        0: v = 31'h7FFF_FFFF;
        1: v = 31'd1;
        2: v = 31'd1024;
        3: v = 31'd1025;
        4: v = 31'd0;
        default: v = ($urandom_range(0, 3) == 0) ? 31'($urandom_range(1, 5000))
                                                 : 31'($urandom);
      endcase
      case (ph % 3)
        0: begin
          tx_idle_pct = 0;
          rx_idle_pct = 30;
        end
        1: begin
          tx_idle_pct = 30;
          rx_idle_pct = 0;
        end
        default: begin
          tx_idle_pct = 15;
          rx_idle_pct = 15;
        end
      endcase
      set_expected(v);
      start = item_n;
      while (item_n - start < PHASE_ITEMS && item_n < ITEM_TARGET - TAIL_ITEMS) begin
        if ($urandom_range(0, 9) < 7) queue_good_frame();
        else queue_noise_frame();
      end
      drain();
      ph++;
    end

    // Last stretch without idling: ordinary frames back to back.
    no_idle = 1'b1;
    set_expected(31'($urandom_range(1, 100000)));
    while (item_n < ITEM_TARGET) queue_good_frame();
    drain();

    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0)
      flag_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
    if (err_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
